FILE: hdl/ppsd_pkg.sv
// Types and widths shared by the point to plane distance pipeline.
package ppsd_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = 33;
   localparam int PROD_W  = 65;
   localparam int SUM_W   = 68;
   localparam int MAG_W   = 67;
   localparam int QSUM_W  = 64;
   localparam int LIMB_W  = 23;
   localparam int PP_W    = 2 * LIMB_W;
   localparam int SQ_W    = 134;
   localparam int KQ_W    = 96;
   localparam int ROOT_W  = 32;
   localparam int IN_W    = 9 * COORD_W;

   typedef struct packed {
      logic signed [COORD_W-1:0] plane_px;
      logic signed [COORD_W-1:0] plane_py;
      logic signed [COORD_W-1:0] plane_pz;
      logic signed [COORD_W-1:0] normal_x;
      logic signed [COORD_W-1:0] normal_y;
      logic signed [COORD_W-1:0] normal_z;
      logic signed [COORD_W-1:0] query_px;
      logic signed [COORD_W-1:0] query_py;
      logic signed [COORD_W-1:0] query_pz;
   } record_type;

   // state handed from cell to cell of the root chain
   typedef struct packed {
      logic [SQ_W-1:0]   rem;
      logic [KQ_W-1:0]   kq;
      logic [ROOT_W-1:0] root;
      logic [QSUM_W-1:0] qsum;
      logic              neg;
      logic              zero;
   } root_data_type;

endpackage

FILE: hdl/point_plane_signed_distance_unit.sv
// Top level of the signed point to plane distance unit.
//
// Input stream req_*: one beat per record (P, N, Q as nine signed Q16.16 words).
// Output stream rsp_*: signed distance N.(Q-P)/|N|, rounded toward zero and
// saturated to 32 bits; rsp_tuser flags a zero normal (distance then 0).
// A record whose nine words are all zero is consumed and gives no beat.
// The pipeline has five front stages (difference, products, sums,
// partial squares, square), 32 root cells each deciding one quotient bit,
// and one output register. Throughput is one record per cycle while rsp_tready
// stays high, set by the root chain which passes its partial state cell to cell.
// Every stage has its own valid bit, so bubbles close up while rsp_tready is
// low; req_tready falls only when all stages hold data.
// Reset (synchronous, active high) clears all valid bits; no beat is lost or
// repeated across a stall.
module point_plane_signed_distance_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // plane_px, plane_py, plane_pz, normal_x, normal_y, normal_z,
   // query_px, query_py, query_pz (32 bits each)
   input  logic [ppsd_pkg::IN_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // distance (32 bits)
   output logic [31:0]               rsp_tdata,
   // zero_normal
   output logic                      rsp_tuser
);
   import ppsd_pkg::*;

   record_type    rec;
   logic          chain_valid [ROOT_W+1];
   logic          chain_ready [ROOT_W+1];
   root_data_type chain_data  [ROOT_W+1];
   root_data_type last;
   logic          out_valid_ff;
   logic          out_adv;
   logic [31:0]   dist_ff, dist_in;
   logic          zero_ff;

   assign rec.plane_px = req_tdata[31:0];
   assign rec.plane_py = req_tdata[63:32];
   assign rec.plane_pz = req_tdata[95:64];
   assign rec.normal_x = req_tdata[127:96];
   assign rec.normal_y = req_tdata[159:128];
   assign rec.normal_z = req_tdata[191:160];
   assign rec.query_px = req_tdata[223:192];
   assign rec.query_py = req_tdata[255:224];
   assign rec.query_pz = req_tdata[287:256];

   ppsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_rec    (rec),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
      ppsd_root_cell #(.BIT(ROOT_W - 1 - g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   assign last               = chain_data[ROOT_W];
   assign out_adv            = !out_valid_ff || rsp_tready;
   assign chain_ready[ROOT_W] = out_adv;

   always_comb begin
      if (last.zero) begin
         dist_in = '0;
      end else if (last.neg) begin
         dist_in = last.root[31] ? 32'h8000_0000 : 32'(-last.root);
      end else begin
         dist_in = last.root[31] ? 32'h7FFF_FFFF : last.root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= chain_valid[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && chain_valid[ROOT_W]) begin
         dist_ff <= dist_in;
         zero_ff <= last.zero;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = dist_ff;
   assign rsp_tuser  = zero_ff;

endmodule

FILE: hdl/ppsd_front.sv
// Front pipeline: differences, products, dot product and norm sums, square of the dot product.
module ppsd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ppsd_pkg::record_type   in_rec,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ppsd_pkg::root_data_type out_data
);
   import ppsd_pkg::*;

   logic [4:0] valid_ff;
   logic [4:0] adv;

   logic signed [DIFF_W-1:0]  diff_ff [3];
   logic signed [COORD_W-1:0] nrm_ff  [3];
   logic signed [PROD_W-1:0]  prod_ff [3];
   logic signed [PROD_W-1:0]  prod_in [3];
   logic [QSUM_W-1:0]         nsq_ff  [3];
   logic [QSUM_W-1:0]         nsq_in  [3];
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic [QSUM_W-1:0]         qsum_c_ff, qsum_d_ff, qsum_e_ff, qsum_in;
   logic [2:0]                neg_ff;
   logic [2:0]                zero_ff;
   logic signed [SUM_W-1:0]   dot;
   logic [LIMB_W-1:0]         a0, a1, a2;
   logic [PP_W-1:0]           pp_ff [6];
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic                      all_zero;

   assign adv[4]   = !valid_ff[4] || out_ready;
   assign adv[3]   = !valid_ff[3] || adv[4];
   assign adv[2]   = !valid_ff[2] || adv[3];
   assign adv[1]   = !valid_ff[1] || adv[2];
   assign adv[0]   = !valid_ff[0] || adv[1];
   assign in_ready = adv[0];

   assign all_zero = (in_rec == '0);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = PROD_W'(nrm_ff[i]) * PROD_W'(diff_ff[i]);
         nsq_in[i]  = QSUM_W'(nrm_ff[i]) * QSUM_W'(nrm_ff[i]);
      end
      dot     = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
      mag_in  = dot[SUM_W-1] ? MAG_W'(-dot) : MAG_W'(dot);
      qsum_in = nsq_ff[0] + nsq_ff[1] + nsq_ff[2];
      a0      = mag_ff[LIMB_W-1:0];
      a1      = mag_ff[2*LIMB_W-1:LIMB_W];
      a2      = LIMB_W'(mag_ff[MAG_W-1:2*LIMB_W]);
      sq_in   = SQ_W'(pp_ff[0])
              + (SQ_W'(pp_ff[1]) << 24)
              + ((SQ_W'(pp_ff[2]) + (SQ_W'(pp_ff[3]) << 1)) << 46)
              + (SQ_W'(pp_ff[4]) << 70)
              + (SQ_W'(pp_ff[5]) << 92);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid && !all_zero;
         if (adv[1]) valid_ff[1] <= valid_ff[0];
         if (adv[2]) valid_ff[2] <= valid_ff[1];
         if (adv[3]) valid_ff[3] <= valid_ff[2];
         if (adv[4]) valid_ff[4] <= valid_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         diff_ff[0] <= DIFF_W'(in_rec.query_px) - DIFF_W'(in_rec.plane_px);
         diff_ff[1] <= DIFF_W'(in_rec.query_py) - DIFF_W'(in_rec.plane_py);
         diff_ff[2] <= DIFF_W'(in_rec.query_pz) - DIFF_W'(in_rec.plane_pz);
         nrm_ff[0]  <= in_rec.normal_x;
         nrm_ff[1]  <= in_rec.normal_y;
         nrm_ff[2]  <= in_rec.normal_z;
      end
      if (adv[1]) begin
         prod_ff <= prod_in;
         nsq_ff  <= nsq_in;
      end
      if (adv[2]) begin
         mag_ff     <= mag_in;
         neg_ff[0]  <= dot[SUM_W-1];
         qsum_c_ff  <= qsum_in;
         zero_ff[0] <= (qsum_in == '0);
      end
      if (adv[3]) begin
         pp_ff[0]   <= PP_W'(a0) * PP_W'(a0);
         pp_ff[1]   <= PP_W'(a0) * PP_W'(a1);
         pp_ff[2]   <= PP_W'(a1) * PP_W'(a1);
         pp_ff[3]   <= PP_W'(a0) * PP_W'(a2);
         pp_ff[4]   <= PP_W'(a1) * PP_W'(a2);
         pp_ff[5]   <= PP_W'(a2) * PP_W'(a2);
         neg_ff[1]  <= neg_ff[0];
         zero_ff[1] <= zero_ff[0];
         qsum_d_ff  <= qsum_c_ff;
      end
      if (adv[4]) begin
         sq_ff      <= sq_in;
         neg_ff[2]  <= neg_ff[1];
         zero_ff[2] <= zero_ff[1];
         qsum_e_ff  <= qsum_d_ff;
      end
   end

   assign out_valid     = valid_ff[4];
   assign out_data.rem  = sq_ff;
   assign out_data.kq   = '0;
   assign out_data.root = '0;
   assign out_data.qsum = qsum_e_ff;
   assign out_data.neg  = neg_ff[2];
   assign out_data.zero = zero_ff[2];

endmodule

FILE: hdl/ppsd_root_cell.sv
// One cell of the root chain: decides one quotient bit of |S| / sqrt(Q).
module ppsd_root_cell #(
   parameter int BIT = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ppsd_pkg::root_data_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ppsd_pkg::root_data_type out_data
);
   import ppsd_pkg::*;

   logic          valid_ff;
   root_data_type data_ff, data_in;
   logic [SQ_W-1:0] trial;
   logic          take;

   // (k + 2^b)^2 Q - k^2 Q = 2^(b+1) kQ + 2^(2b) Q
   always_comb begin
      trial   = (SQ_W'(in_data.kq) << (BIT + 1)) + (SQ_W'(in_data.qsum) << (2 * BIT));
      take    = trial <= in_data.rem;
      data_in = in_data;
      if (take) begin
         data_in.rem       = in_data.rem - trial;
         data_in.kq        = in_data.kq + (KQ_W'(in_data.qsum) << BIT);
         data_in.root[BIT] = 1'b1;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: test/point_plane_signed_distance_unit_tb.sv
// Testbench for the point to plane signed distance unit: directed and random records.
`timescale 1ns / 1ps

module point_plane_signed_distance_unit_tb;
   import ppsd_pkg::*;

   typedef struct {
      logic [31:0] distance;
      logic        zero_normal;
   } dist_result_type;

   typedef logic [COORD_W-1:0] coord_arr_type [9];

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [IN_W-1:0]     req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;
   logic                rsp_tuser;

   dist_result_type     pending_distances[$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   bit                  send_gaps = 1'b0;
   bit                  recv_stalls = 1'b0;
   bit                  hold_request = 1'b0;
   int                  hold_count = 0;
   int                  stall_count = 0;

   point_plane_signed_distance_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: long hold on request, otherwise random stall bursts
   always @(posedge clock) begin
      if (hold_request && hold_count == 0) begin
         hold_count = 300;
         hold_request = 1'b0;
      end
      if (hold_count > 0) begin
         hold_count = hold_count - 1;
         rsp_tready <= 1'b0;
      end else if (stall_count > 0) begin
         stall_count = stall_count - 1;
         rsp_tready <= 1'b0;
      end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
         stall_count = $urandom_range(1, 14) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void predict_distance(input coord_arr_type f);
      logic signed [67:0]  s;
      logic signed [67:0]  nv;
      logic signed [67:0]  dv;
      logic [67:0]         s_mag;
      logic [139:0]        s_sq;
      logic [139:0]        c_prod;
      logic [65:0]         qsum;
      logic [32:0]         k;
      logic [32:0]         c;
      logic                neg;
      bit                  all_zero;
      dist_result_type     r;
      all_zero = 1'b1;
      for (int i = 0; i < 9; i++)
         if (f[i] != 0) all_zero = 1'b0;
      if (all_zero) return;
      s = '0;
      qsum = '0;
      for (int i = 0; i < 3; i++) begin
         nv = 68'($signed(f[3+i]));
         dv = 68'($signed(f[6+i])) - 68'($signed(f[i]));
         s = s + nv * dv;
         qsum = qsum + 66'(nv * nv);
      end
      if (qsum == 0) begin
         r.distance = '0;
         r.zero_normal = 1'b1;
      end else begin
         neg = s < 0;
         s_mag = neg ? -s : s;
         s_sq = 140'(s_mag) * 140'(s_mag);
         k = '0;
         for (int b = 31; b >= 0; b--) begin
            c = k | (33'd1 << b);
            c_prod = 140'(c) * 140'(c) * 140'(qsum);
            if (c_prod <= s_sq) k = c;
         end
         if (neg && k > 33'h080000000) k = 33'h080000000;
         if (!neg && k > 33'h07fffffff) k = 33'h07fffffff;
         r.distance = neg ? 32'(-k) : 32'(k);
         r.zero_normal = 1'b0;
      end
      pending_distances.push_back(r);
   endfunction

   always @(posedge clock) begin
      dist_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_distances.size() == 0) begin
            $display("%0t: unexpected beat distance %h zero_normal %b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            exp_r = pending_distances.pop_front();
            if (rsp_tdata !== exp_r.distance) begin
               $display("%0t: distance expected %h actual %h",
                        $time, exp_r.distance, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== exp_r.zero_normal) begin
               $display("%0t: zero_normal expected %b actual %b",
                        $time, exp_r.zero_normal, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   task automatic send_record(input coord_arr_type f);
      logic [IN_W-1:0] packed_rec;
      for (int i = 0; i < 9; i++)
         packed_rec[i*COORD_W +: COORD_W] = f[i];
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= packed_rec;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_distance(f);
   endtask

   task automatic idle_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'h0;
         3: return $urandom_range(0, 1) ? 32'($urandom_range(0, 16'hffff))
                                       : -32'($urandom_range(0, 16'hffff));
         4: return $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h00ffffff))
                                       : -32'($urandom_range(0, 32'h00ffffff));
         default: return $urandom;
      endcase
   endfunction

   function automatic coord_arr_type random_record();
      coord_arr_type f;
      int mode;
      mode = $urandom_range(0, 19);
      for (int i = 0; i < 9; i++) f[i] = random_coord();
      if (mode == 0) begin
         for (int i = 0; i < 9; i++) f[i] = '0;
      end else if (mode == 1) begin
         for (int i = 3; i < 6; i++) f[i] = '0;
      end else if (mode == 2) begin
         f[3] = $urandom; f[4] = '0; f[5] = '0;
      end
      return f;
   endfunction

   task automatic wait_drained();
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic test_directed();
      coord_arr_type f;
      coord_arr_type all_max;
      coord_arr_type all_min;
      for (int i = 0; i < 9; i++) begin
         all_max[i] = 32'h7fffffff;
         all_min[i] = 32'h80000000;
      end
      f = '{default: 32'h0};
      send_record(f);                                   // empty record, no beat
      send_record(all_max);
      send_record(all_min);
      f = '{default: 32'h0}; f[0] = 32'h00010000;       // zero normal
      send_record(f);
      f = all_max; f[3] = 0; f[4] = 0; f[5] = 0;
      send_record(f);
      // positive saturation
      f = '{default: 32'h0}; f[3] = 32'h7fffffff; f[0] = 32'h80000000; f[6] = 32'h7fffffff;
      send_record(f);
      // negative saturation
      f = '{default: 32'h0}; f[3] = 32'h7fffffff; f[0] = 32'h7fffffff; f[6] = 32'h80000000;
      send_record(f);
      f = '{default: 32'h0}; f[3] = 32'h80000000; f[0] = 32'h7fffffff; f[6] = 32'h80000000;
      send_record(f);
      // exact -2^31
      f = '{default: 32'h0}; f[5] = 32'h00010000; f[8] = 32'h80000000;
      send_record(f);
      // unit normal, small distances both signs
      f = '{default: 32'h0}; f[4] = 32'h00010000; f[7] = 32'h00038000;
      send_record(f);
      f[7] = 32'hfffc8000;
      send_record(f);
      // 3-4-5 normal
      f = '{default: 32'h0}; f[3] = 32'h00030000; f[4] = 32'h00040000;
      f[6] = 32'h00050000; f[7] = 32'h00050000;
      send_record(f);
      // query on the plane
      f = '{default: 32'h12345678}; f[3] = 32'hfff00000; f[4] = 32'h1; f[5] = 32'h7;
      send_record(f);
      // tiny normal, rounding toward zero
      f = '{default: 32'h0}; f[3] = 32'h1; f[4] = 32'h1; f[6] = 32'h1;
      send_record(f);
      f[6] = 32'hffffffff;
      send_record(f);
      for (int i = 0; i < 9; i++) f[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
      send_record(f);
      for (int i = 0; i < 9; i++) f[i] = 32'hffffffff;
      send_record(f);
      idle_sender();
      wait_drained();
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) send_record(random_record());
      idle_sender();
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      @(posedge clock);
      for (int n = 0; n < 120; n++) send_record(random_record());
      idle_sender();
      wait_drained();
   endtask

   task automatic test_sender_pause();
      for (int n = 0; n < 60; n++) send_record(random_record());
      idle_sender();
      wait_drained();
      for (int n = 0; n < 60; n++) send_record(random_record());
      idle_sender();
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_gaps = 1'b1;
      recv_stalls = 1'b1;
      test_random(600);
      test_backpressure();
      test_sender_pause();
      send_gaps = 1'b0;
      recv_stalls = 1'b0;
      test_random(250);
      wait_drained();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/ppsd_pkg.sv
hdl/ppsd_front.sv
hdl/ppsd_root_cell.sv
hdl/point_plane_signed_distance_unit.sv
test/point_plane_signed_distance_unit_tb.sv
